[sv/ofj_pkg.sv]
package ofj_pkg;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int FRAC_W  = 8;
  localparam int CLASS_W = 8;
  localparam int JOY_W   = 8;
  localparam int IDX_W   = 3;
  localparam int QUOT_W  = 7;
  // widest product: 8-bit fraction times 13-bit dimension
  localparam int PROD_W  = FRAC_W + DIM_W;

  localparam logic [QUOT_W-1:0] PERCENT = 7'd100;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_CLASS = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTER_FRAC  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SIZE_MIN     = 3'd4;
  localparam logic [IDX_W-1:0] REG_SIZE_MAX     = 3'd5;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CLASS_W-1:0] RST_TARGET_CLASS = 8'd39;
  localparam logic [FRAC_W-1:0]  RST_CENTER_FRAC  = 8'd26;
  localparam logic [FRAC_W-1:0]  RST_SIZE_MIN     = 8'd26;
  localparam logic [FRAC_W-1:0]  RST_SIZE_MAX     = 8'd102;

endpackage

[sv/ofj_div.sv]
module ofj_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ofj_pkg::PROD_W-1:0]  dividend,
  input  logic [ofj_pkg::DIM_W-1:0]   divisor,
  output logic                        done,
  output logic [ofj_pkg::QUOT_W-1:0]  quotient
);
  import ofj_pkg::*;

  localparam int SHIFT_W = DIM_W + QUOT_W - 1;
  localparam int CNT_W   = $clog2(QUOT_W);

  logic [PROD_W-1:0]  rem;
  logic [SHIFT_W-1:0] ds;
  logic [QUOT_W-1:0]  q;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               sat;
  logic               zero;
  logic               ge;

  assign ge = rem >= PROD_W'(ds);

  // seven restoring steps; a quotient of 128 or more is caught up front
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend;
        ds   <= {divisor, {(QUOT_W-1){1'b0}}};
        q    <= '0;
        cnt  <= CNT_W'(QUOT_W - 1);
        sat  <= dividend >= PROD_W'({divisor, {QUOT_W{1'b0}}});
        zero <= divisor == '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - PROD_W'(ds);
        end
        ds <= ds >> 1;
        q  <= {q[QUOT_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero) begin
      quotient = '0;
    end else if (sat || q > PERCENT) begin
      quotient = PERCENT;
    end else begin
      quotient = q;
    end
  end

endmodule

[sv/object_follow_joystick.sv]
// Follow-object joystick. Detection boxes of a frame arrive one per
// transaction; the first box whose class matches target_class is kept, and on
// the frame's last box one result carries joystick x/y in percent (truncated,
// saturated to +/-100, zeroed per axis when centered or inside the size band)
// plus target_found. The kept box first uses one shared 8x13 multiplier for
// the three thresholds and the x percent product, then makes two passes of
// one shared restoring divider (a start, seven steps, then taking the
// quotient), with the y percent product formed in the first start state.
// A last box then loads the output register and waits there for as long as
// the previous result has not been taken; the register then holds the result
// while the next frame's boxes are already taken. Configuration is written
// through cfg_write/cfg_index/cfg_data; the user must write it only while
// idle, and the block itself does not enforce this.
module object_follow_joystick (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [ofj_pkg::IDX_W-1:0]          cfg_index,
  input  logic [ofj_pkg::DIM_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               box_present,
  input  logic [ofj_pkg::CLASS_W-1:0]        class_label,
  input  logic [ofj_pkg::COORD_W-1:0]        box_left,
  input  logic [ofj_pkg::COORD_W-1:0]        box_top,
  input  logic [ofj_pkg::COORD_W-1:0]        box_w,
  input  logic [ofj_pkg::COORD_W-1:0]        box_h,
  input  logic                               last_box,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ofj_pkg::JOY_W-1:0]   steer_pct,
  output logic signed [ofj_pkg::JOY_W-1:0]   drive_pct,
  output logic                               target_found
);
  import ofj_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MC   = 4'd1;
  localparam logic [3:0] S_MMIN = 4'd2;
  localparam logic [3:0] S_MMAX = 4'd3;
  localparam logic [3:0] S_MX   = 4'd4;
  localparam logic [3:0] S_DXS  = 4'd5;
  localparam logic [3:0] S_DXW  = 4'd6;
  localparam logic [3:0] S_DYS  = 4'd7;
  localparam logic [3:0] S_DYW  = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]         state;
  logic [3:0]         state_next;

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [CLASS_W-1:0] target_class;
  logic [FRAC_W-1:0]  center_fraction;
  logic [FRAC_W-1:0]  size_min_fraction;
  logic [FRAC_W-1:0]  size_max_fraction;

  logic               matched;
  logic [JOY_W-1:0]   held_x;
  logic [JOY_W-1:0]   held_y;

  logic               last_r;
  logic [DIM_W-1:0]   cx;
  logic [DIM_W-1:0]   cy;
  logic [COORD_W-1:0] bw_r;
  logic [DIM_W-1:0]   adx;
  logic [DIM_W-1:0]   ady;
  logic               dx_neg;
  logic               dy_neg;
  logic               centered;
  logic               ge_min;
  logic               in_band;

  logic [FRAC_W-1:0]  mul_a;
  logic [DIM_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;
  logic               prod_en;

  logic [DIM_W:0]     dx_full;
  logic [DIM_W:0]     dy_full;
  logic [PROD_W-1:0]  bw_scaled;

  logic               accept;
  logic               hit;
  logic               div_start;
  logic               div_done;
  logic [DIM_W-1:0]   div_divisor;
  logic [QUOT_W-1:0]  div_q;
  logic [JOY_W-1:0]   q_pos;
  logic [JOY_W-1:0]   q_neg;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign hit      = box_present && !matched && class_label == target_class;

  assign dx_full   = {1'b0, cx} - {2'b0, frame_width[DIM_W-1:1]};
  assign dy_full   = {2'b0, frame_height[DIM_W-1:1]} - {1'b0, cy};
  assign bw_scaled = PROD_W'({bw_r, 8'b0});

  assign div_start   = state == S_DXS || state == S_DYS;
  assign div_divisor = (state == S_DXS) ? frame_width : frame_height;
  assign q_pos       = {1'b0, div_q};
  assign q_neg       = -q_pos;

  // one multiplier, operands picked by the sequencer
  always_comb begin
    prod_en = 1'b1;
    case (state)
      S_MC: begin
        mul_a = center_fraction;
        mul_b = frame_width;
      end
      S_MMIN: begin
        mul_a = size_min_fraction;
        mul_b = frame_width;
      end
      S_MMAX: begin
        mul_a = size_max_fraction;
        mul_b = frame_width;
      end
      S_MX: begin
        mul_a = {1'b0, PERCENT};
        mul_b = adx;
      end
      S_DXS: begin
        mul_a = {1'b0, PERCENT};
        mul_b = ady;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        prod_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod <= mul_a * mul_b;
    end
  end

  ofj_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (hit) begin
            state_next = S_MC;
          end else if (last_box) begin
            state_next = S_EMIT;
          end
        end
      end
      S_MC:   state_next = S_MMIN;
      S_MMIN: state_next = S_MMAX;
      S_MMAX: state_next = S_MX;
      S_MX:   state_next = S_DXS;
      S_DXS:  state_next = S_DXW;
      S_DXW: begin
        if (div_done) begin
          state_next = S_DYS;
        end
      end
      S_DYS:  state_next = S_DYW;
      S_DYW: begin
        if (div_done) begin
          state_next = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      frame_width       <= RST_FRAME_WIDTH;
      frame_height      <= RST_FRAME_HEIGHT;
      target_class      <= RST_TARGET_CLASS;
      center_fraction   <= RST_CENTER_FRAC;
      size_min_fraction <= RST_SIZE_MIN;
      size_max_fraction <= RST_SIZE_MAX;
      matched           <= 1'b0;
      held_x            <= '0;
      held_y            <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width       <= cfg_data;
          REG_FRAME_HEIGHT: frame_height      <= cfg_data;
          REG_TARGET_CLASS: target_class      <= cfg_data[CLASS_W-1:0];
          REG_CENTER_FRAC:  center_fraction   <= cfg_data[FRAC_W-1:0];
          REG_SIZE_MIN:     size_min_fraction <= cfg_data[FRAC_W-1:0];
          REG_SIZE_MAX:     size_max_fraction <= cfg_data[FRAC_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_DXW: begin
          if (div_done) begin
            held_x <= centered ? '0 : (dx_neg ? q_neg : q_pos);
          end
        end
        S_DYW: begin
          if (div_done) begin
            held_y  <= in_band ? '0 : (dy_neg ? q_neg : q_pos);
            matched <= 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            matched   <= 1'b0;
            held_x    <= '0;
            held_y    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // per-box datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          last_r <= last_box;
          cx     <= {1'b0, box_left} + {2'b0, box_w[COORD_W-1:1]};
          cy     <= {1'b0, box_top} + {2'b0, box_h[COORD_W-1:1]};
          bw_r   <= box_w;
        end
      end
      S_MC: begin
        dx_neg <= dx_full[DIM_W];
        adx    <= dx_full[DIM_W] ? DIM_W'(-dx_full) : dx_full[DIM_W-1:0];
        dy_neg <= dy_full[DIM_W];
        ady    <= dy_full[DIM_W] ? DIM_W'(-dy_full) : dy_full[DIM_W-1:0];
      end
      S_MMIN: centered <= PROD_W'({adx, 8'b0}) < prod;
      S_MMAX: ge_min   <= bw_scaled >= prod;
      S_MX:   in_band  <= ge_min && bw_scaled <= prod;
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          steer_pct    <= matched ? held_x : '0;
          drive_pct    <= matched ? held_y : '0;
          target_found <= matched;
        end
      end
      default: ;
    endcase
  end

endmodule
